### rtl/utx_pkg.sv
package utx_pkg;

   // Item operation codes.
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_SEND = 1'b1
   } op_type;

   // Parity mode codes; the remaining codes mean no parity.
   localparam logic [1:0] EVEN_PARITY = 2'd1;
   localparam logic [1:0] ODD_PARITY  = 2'd2;

   // Stop bit count codes at or above this value select two stop bits.
   localparam logic [1:0] STOP_TWO = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CYCLES_PER_BIT = 2'd0;
   localparam logic [1:0] CSR_DATA_BIT_COUNT = 2'd1;
   localparam logic [1:0] CSR_PARITY_MODE    = 2'd2;
   localparam logic [1:0] CSR_STOP_BIT_COUNT = 2'd3;

   // Configuration reset values.
   localparam logic [19:0] RST_CYCLES_PER_BIT = 20'd694;
   localparam logic [3:0]  RST_DATA_BIT_COUNT = 4'd8;
   localparam logic [1:0]  RST_PARITY_MODE    = 2'd0;
   localparam logic [1:0]  RST_STOP_BIT_COUNT = 2'd1;

   // Legal data bit range.
   localparam logic [3:0] MIN_DATA_BITS = 4'd5;
   localparam logic [3:0] MAX_DATA_BITS = 4'd8;

   // Parity of a nibble, indexed by the nibble.
   localparam logic [15:0] PARITY_LUT  = 16'h6996;
   localparam logic [3:0]  NIBBLE_MASK = 4'hF;

   // Frame register width: start bit, eight data bits and parity.
   localparam int FRAME_W = 10;

   typedef struct packed {
      logic       operation;
      logic [7:0] tx_byte;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic refused;
   } rsp_type;

   typedef struct packed {
      logic [19:0] cycles_per_bit;
      logic [3:0]  data_bit_count;
      logic [1:0]  parity_mode;
      logic [1:0]  stop_bit_count;
   } cfg_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic               is_send;
      logic [FRAME_W-1:0] frame;
      logic [3:0]         frame_bits;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Returns 1 when the byte holds an odd number of ones.
   function automatic logic odd_ones(input logic [7:0] b);
      logic [3:0] idx;
      idx = (b[3:0] ^ b[7:4]) & NIBBLE_MASK;
      return PARITY_LUT[idx];
   endfunction

endpackage

### rtl/utx_front.sv
module utx_front
   import utx_pkg::*;
(
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_payload,
   input  cfg_type      cfg,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   logic [3:0] n_data;
   logic [7:0] data;
   logic       par_en;
   logic       par_bit;

   // Accept whenever the queue has room.
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // Build the complete frame for a send item from the current format.
   always_comb begin
      if (cfg.data_bit_count < MIN_DATA_BITS) begin
         n_data = MIN_DATA_BITS;
      end else if (cfg.data_bit_count > MAX_DATA_BITS) begin
         n_data = MAX_DATA_BITS;
      end else begin
         n_data = cfg.data_bit_count;
      end

      for (int i = 0; i < 8; i++) begin
         data[i] = req_payload.tx_byte[i] && (4'(i) < n_data);
      end

      par_en  = (cfg.parity_mode == EVEN_PARITY) || (cfg.parity_mode == ODD_PARITY);
      par_bit = odd_ones(data) ^ (cfg.parity_mode == ODD_PARITY);

      // The start bit sits at the bottom; parity follows the last data bit.
      push_cmd.frame    = '0;
      for (int i = 0; i < 9; i++) begin
         if (4'(i) < n_data) begin
            push_cmd.frame[i+1] = data[i];
         end else if ((4'(i) == n_data) && par_en) begin
            push_cmd.frame[i+1] = par_bit;
         end
      end

      push_cmd.is_send    = (op_type'(req_payload.operation) == OP_SEND);
      push_cmd.frame_bits = n_data + {3'b000, par_en} + 4'd1;
   end

endmodule

### rtl/utx_queue.sv
module utx_queue
   import utx_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

### rtl/utx_back.sv
module utx_back
   import utx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  cmd_type      head_cmd,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_payload
);

   logic [FRAME_W-1:0] frame_shift_ff, frame_shift_in;
   logic [3:0]         bits_left_ff, bits_left_in;
   logic [19:0]        tick_count_ff, tick_count_in;
   logic [20:0]        stop_ticks_ff, stop_ticks_in;
   logic               line_ff, line_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   logic               take;
   logic               busy;
   logic               refused;
   logic [19:0]        bit_len;
   logic [19:0]        tick_next;
   logic [20:0]        stop_total;
   logic [FRAME_W-1:0] shifted;
   logic [3:0]         bits_dec;

   // Execute the head item whenever the result register is free or drains.
   assign take = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop  = take;

   assign busy       = (bits_left_ff != '0) || (stop_ticks_ff != '0);
   assign bit_len    = (cfg.cycles_per_bit == '0) ? 20'd1 : cfg.cycles_per_bit;
   assign stop_total = (cfg.stop_bit_count >= STOP_TWO) ? {bit_len, 1'b0}
                                                        : {1'b0, bit_len};
   assign tick_next  = tick_count_ff + 20'd1;
   assign shifted    = {1'b1, frame_shift_ff[FRAME_W-1:1]};
   assign bits_dec   = bits_left_ff - 4'd1;

   // Line state update for one item.
   always_comb begin
      frame_shift_in = frame_shift_ff;
      bits_left_in   = bits_left_ff;
      tick_count_in  = tick_count_ff;
      stop_ticks_in  = stop_ticks_ff;
      line_in        = line_ff;
      refused        = 1'b0;

      if (take) begin
         if (head_cmd.is_send) begin
            if (busy) begin
               refused = 1'b1;
            end else begin
               frame_shift_in = head_cmd.frame;
               bits_left_in   = head_cmd.frame_bits;
               tick_count_in  = '0;
               line_in        = head_cmd.frame[0];
            end
         end else if (bits_left_ff != '0) begin
            if (tick_next >= bit_len) begin
               tick_count_in  = '0;
               frame_shift_in = shifted;
               bits_left_in   = bits_dec;
               if (bits_dec != '0) begin
                  line_in = shifted[0];
               end else begin
                  line_in       = 1'b1;
                  stop_ticks_in = stop_total;
               end
            end else begin
               tick_count_in = tick_next;
            end
         end else if (stop_ticks_ff != '0) begin
            stop_ticks_in = stop_ticks_ff - 21'd1;
         end
      end
   end

   // Result register: holds while stalled, loads on every executed item.
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (take) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.line_level = line_in;
         rsp_payload_in.busy_res   = (bits_left_in != '0) || (stop_ticks_in != '0);
         rsp_payload_in.refused    = refused;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_shift_ff <= '1;
         bits_left_ff   <= '0;
         tick_count_ff  <= '0;
         stop_ticks_ff  <= '0;
         line_ff        <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_shift_ff <= frame_shift_in;
         bits_left_ff   <= bits_left_in;
         tick_count_ff  <= tick_count_in;
         stop_ticks_ff  <= stop_ticks_in;
         line_ff        <= line_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### rtl/uart_frame_transmitter.sv
// UART frame transmitter. Each item is either a tick, which advances bit
// timing by one step, or a send request, which loads a frame of a low start
// bit, 5 to 8 data bits LSB first and an optional parity bit, followed by one
// or two high stop bits; a send while busy is refused and flagged. Every item
// yields exactly one result carrying the line level, busy flag and refusal
// flag. The block takes one item per clock and delivers one result per clock,
// unless the result side stalls; each result is registered first in the queue
// after the combinational front classifier, then in the back unit, whose state
// update sets the rate. The queue between them is QUEUE_DEPTH entries deep.
// Configuration writes are always ready and take effect on the next cycle.
module uart_frame_transmitter
   import utx_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   cmd_type      push_cmd;
   cmd_type      head_cmd;
   logic         push;
   logic         pop;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CYCLES_PER_BIT: cfg_in.cycles_per_bit = csr_wdata;
            CSR_DATA_BIT_COUNT: cfg_in.data_bit_count = csr_wdata[3:0];
            CSR_PARITY_MODE:    cfg_in.parity_mode    = csr_wdata[1:0];
            CSR_STOP_BIT_COUNT: cfg_in.stop_bit_count = csr_wdata[1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycles_per_bit <= RST_CYCLES_PER_BIT;
         cfg_ff.data_bit_count <= RST_DATA_BIT_COUNT;
         cfg_ff.parity_mode    <= RST_PARITY_MODE;
         cfg_ff.stop_bit_count <= RST_STOP_BIT_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accepts and classifies items.
   utx_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Queue between front and back.
   utx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   // Back: drives the line state and the result register.
   utx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_cmd    (head_cmd),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A refused send can only happen while the transmitter is busy.
   a_refused_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.refused) |-> rsp_payload.busy_res)
      else $error("refused result without busy");

   // An idle transmitter holds the line high.
   a_idle_high : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.busy_res) |-> rsp_payload.line_level)
      else $error("line low while idle");

   // An item pushed without a pop leaves the queue non-empty.
   a_queue_fill : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !q_status.empty)
      else $error("queue lost an item");

endmodule

### bench/uart_frame_transmitter_test.sv
`timescale 1ns / 100ps

module uart_frame_transmitter_test;
   import utx_pkg::*;

   // Parity codes that the package leaves unnamed.
   localparam logic [1:0] PARITY_NONE  = 2'd0;
   localparam logic [1:0] PARITY_SPARE = 2'd3;

   localparam int STALL_LIMIT   = 2000;
   localparam int PHASES        = 14;
   localparam int PHASE_ITEMS   = 125;
   localparam int SETTLE_CYCLES = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [19:0] csr_wdata;

   bit no_gaps;
   int rsp_hold;
   int idle_cycles;

   // Tracks the serial line and keeps the results each accepted item should produce.
   class line_scoreboard;
      cfg_type    cfg;
      logic [9:0] frame_shift;
      logic [3:0] bits_left;
      logic [19:0] tick_count;
      logic [20:0] stop_ticks_left;
      logic       line_reg;
      rsp_type    predicted_rsp[$];
      int         errors;

      function new();
         cfg = '{RST_CYCLES_PER_BIT, RST_DATA_BIT_COUNT, RST_PARITY_MODE,
                 RST_STOP_BIT_COUNT};
         frame_shift = '1;
         bits_left = '0;
         tick_count = '0;
         stop_ticks_left = '0;
         line_reg = 1'b1;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [19:0] data);
         case (index)
            CSR_CYCLES_PER_BIT: cfg.cycles_per_bit = data;
            CSR_DATA_BIT_COUNT: cfg.data_bit_count = data[3:0];
            CSR_PARITY_MODE:    cfg.parity_mode = data[1:0];
            CSR_STOP_BIT_COUNT: cfg.stop_bit_count = data[1:0];
            default: ;
         endcase
      endfunction

      function bit is_busy();
         return bits_left != 0 || stop_ticks_left != 0;
      endfunction

      // A bit length of zero behaves as one tick.
      function int unsigned bit_ticks();
         return cfg.cycles_per_bit == 0 ? 1 : cfg.cycles_per_bit;
      endfunction

      // Moves the line on by one item and queues the result that item causes.
      function void advance_line(req_type item);
         int unsigned ndata;
         int unsigned stops;
         logic        with_parity;
         logic [9:0]  data_bits;
         rsp_type     res;
         res.refused = 1'b0;
         if (item.operation == OP_SEND) begin
            if (is_busy()) begin
               res.refused = 1'b1;
            end else begin
               // Out-of-range data widths clamp to the nearest legal width.
               ndata = (cfg.data_bit_count < MIN_DATA_BITS) ? MIN_DATA_BITS :
                       (cfg.data_bit_count > MAX_DATA_BITS) ? MAX_DATA_BITS :
                       cfg.data_bit_count;
               with_parity = cfg.parity_mode == EVEN_PARITY ||
                             cfg.parity_mode == ODD_PARITY;
               data_bits = 10'(item.tx_byte & ((1 << ndata) - 1));
               if (with_parity) begin
                  data_bits[ndata] = (^data_bits) ^ (cfg.parity_mode == ODD_PARITY);
               end
               frame_shift = {data_bits[8:0], 1'b0};
               bits_left = 4'(ndata + with_parity + 1);
               tick_count = '0;
               line_reg = frame_shift[0];
            end
         end else if (bits_left != 0) begin
            tick_count = tick_count + 1'b1;
            if (tick_count >= bit_ticks()) begin
               tick_count = '0;
               frame_shift = {1'b1, frame_shift[9:1]};
               bits_left = bits_left - 1'b1;
               if (bits_left != 0) begin
                  line_reg = frame_shift[0];
               end else begin
                  // The last frame bit is done, so the stop bits begin.
                  stops = (cfg.stop_bit_count >= STOP_TWO) ? 2 : 1;
                  line_reg = 1'b1;
                  stop_ticks_left = 21'(bit_ticks() * stops);
               end
            end
         end else if (stop_ticks_left != 0) begin
            stop_ticks_left = stop_ticks_left - 1'b1;
         end
         res.line_level = line_reg;
         res.busy_res = is_busy();
         predicted_rsp.push_back(res);
      endfunction

      task report(string what);
         $display("%0t: %s", $time, what);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (predicted_rsp.size() == 0) begin
            report($sformatf("result %b arrived with no item waiting", got));
         end else begin
            want = predicted_rsp.pop_front();
            if (got.line_level !== want.line_level) begin
               report($sformatf("line_level %b, wanted %b", got.line_level,
                                want.line_level));
            end
            if (got.busy_res !== want.busy_res) begin
               report($sformatf("busy_res %b, wanted %b", got.busy_res, want.busy_res));
            end
            if (got.refused !== want.refused) begin
               report($sformatf("refused %b, wanted %b", got.refused, want.refused));
            end
         end
      endtask
   endclass

   line_scoreboard board;

   uart_frame_transmitter dut (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Samples both channels at the rising edge and watches for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.advance_line(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_result(rsp_payload);
            rsp_hold = no_gaps ? 0 : $urandom_range(0, 3);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("uart_frame_transmitter_test failed");
            $finish;
         end
      end
   end

   // The result side holds off for the number of cycles drawn after each result.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offers one item after a random gap and returns at the falling edge after it
   // is taken. Valid stays high so a following item can go out back to back.
   task send_item(input op_type op, input logic [7:0] data);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{operation: op, tx_byte: data};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task wait_results();
      while (board.predicted_rsp.size() != 0) @(negedge clock);
   endtask

   // Writes the selected registers, sometimes with junk above the used bits.
   task write_config(input cfg_type c, input logic [3:0] pick);
      logic [19:0] data;
      logic [19:0] junk;
      logic [1:0]  index;
      for (int i = 0; i < 4; i++) begin
         index = 2'(i);
         junk = ($urandom_range(0, 3) == 0) ? 20'($urandom) : '0;
         case (index)
            CSR_CYCLES_PER_BIT: data = c.cycles_per_bit;
            CSR_DATA_BIT_COUNT: data = {junk[19:4], c.data_bit_count};
            CSR_PARITY_MODE:    data = {junk[19:2], c.parity_mode};
            default:            data = {junk[19:2], c.stop_bit_count};
         endcase
         if (pick[index]) begin
            csr_valid <= 1'b1;
            csr_index <= index;
            csr_wdata <= data;
            do @(posedge clock); while (!csr_ready);
            board.write_reg(index, data);
            @(negedge clock);
         end
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly short bit lengths so that many frames finish within a phase.
   function automatic cfg_type pick_config();
      cfg_type c;
      int      r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         c.cycles_per_bit = '0;
      end else if (r < 70) begin
         c.cycles_per_bit = 20'($urandom_range(1, 3));
      end else if (r < 92) begin
         c.cycles_per_bit = 20'($urandom_range(4, 9));
      end else begin
         c.cycles_per_bit = 20'($urandom_range(10, 24));
      end
      c.data_bit_count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) :
                         4'($urandom_range(MIN_DATA_BITS, MAX_DATA_BITS));
      c.parity_mode = 2'($urandom_range(0, 3));
      c.stop_bit_count = 2'($urandom_range(0, 3));
      return c;
   endfunction

   // Sends chiefly while the line is free; sends during a frame get refused.
   task run_phase(int count);
      op_type op;
      for (int n = 0; n < count; n++) begin
         if (board.is_busy()) begin
            op = ($urandom_range(0, 15) == 0) ? OP_SEND : OP_TICK;
         end else begin
            op = ($urandom_range(0, 3) != 0) ? OP_SEND : OP_TICK;
         end
         send_item(op, 8'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      cfg_type setting;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_gaps = 1'b0;
      rsp_hold = 0;
      idle_cycles = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: idle tick, a send, and a send refused during the frame.
      send_item(OP_TICK, 8'h00);
      send_item(OP_SEND, 8'hA5);
      send_item(OP_TICK, 8'hFF);
      send_item(OP_TICK, 8'h00);
      send_item(OP_SEND, 8'h3C);
      req_valid <= 1'b0;
      wait_results();

      // Longest bit length mid-frame, with zero data and stop bit codes and odd parity.
      setting = '{20'hFFFFF, 4'd0, ODD_PARITY, 2'd0};
      write_config(setting, 4'b1111);
      send_item(OP_TICK, 8'h00);
      send_item(OP_TICK, 8'hFF);
      req_valid <= 1'b0;
      wait_results();

      // Zero bit length cuts the long bit short; then a full frame and stop bits.
      setting = '{20'd0, 4'd15, PARITY_SPARE, 2'd3};
      write_config(setting, 4'b1111);
      repeat (12) send_item(OP_TICK, 8'h00);
      send_item(OP_SEND, 8'hFF);
      send_item(OP_TICK, 8'h00);
      req_valid <= 1'b0;

      // Random phases, each under its own settings, some without any idling.
      for (int p = 0; p < PHASES; p++) begin
         wait_results();
         no_gaps = ($urandom_range(0, 3) == 0);
         setting = pick_config();
         write_config(setting, (p == 0) ? 4'b1111 : 4'($urandom_range(1, 15)));
         run_phase(PHASE_ITEMS);
      end
      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (board.errors == 0) begin
         $display("uart_frame_transmitter_test passed");
      end else begin
         $display("uart_frame_transmitter_test failed");
      end
      $finish;
   end

endmodule

### uart_frame_transmitter.f
rtl/utx_pkg.sv
rtl/utx_front.sv
rtl/utx_queue.sv
rtl/utx_back.sv
rtl/uart_frame_transmitter.sv
bench/uart_frame_transmitter_test.sv
